[sv/lph_pkg.sv]
// Shared types and constants of the linear probing hash table.
package lph_pkg;

   localparam int OP_W       = 2;
   localparam int KEY_W      = 31;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] SLOT_EMPTY = 2'd0;
   localparam logic [1:0] SLOT_USED  = 2'd1;
   localparam logic [1:0] SLOT_TOMB  = 2'd2;

   localparam logic [STATUS_W-1:0] RSP_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_FULL = 2'd2;

   localparam logic signed [VALUE_W-1:0] VALUE_MISS = '1;

   typedef struct packed {
      logic [1:0]                 status;
      logic [KEY_W-1:0]           key;
      logic signed [VALUE_W-1:0]  value;
   } slot_word_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE
   } state_type;

endpackage

[sv/lph_if.sv]
// Request and response channel interfaces of the hash table.
interface lph_req_if import lph_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            opcode;
   logic [KEY_W-1:0]           key;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, opcode, key, value, input ready);
   modport sink (input valid, opcode, key, value, output ready);
endinterface

interface lph_rsp_if import lph_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [VALUE_W-1:0]  value_out;

   modport source (output valid, status, value_out, input ready);
   modport sink (input valid, status, value_out, output ready);
endinterface

[sv/lph_slot_mem.sv]
// Slot memory holding status, key and value, one write and one registered read port.
module lph_slot_mem import lph_pkg::*; #(
   parameter int TABLE_SLOTS = 8,
   parameter int IDX_W       = 3
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  slot_word_type  wr_word,
   input  logic [IDX_W-1:0] rd_addr,
   output slot_word_type  rd_word
);

   slot_word_type mem [TABLE_SLOTS];
   slot_word_type rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
      rd_word_ff <= mem[rd_addr];
   end

   assign rd_word = rd_word_ff;

endmodule

[sv/lph_hash.sv]
// Home slot unit: key modulo the slot count by a mask or a reciprocal multiplication.
module lph_hash import lph_pkg::*; #(
   parameter int TABLE_SLOTS = 8,
   parameter int IDX_W       = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   output logic             done,
   output logic [IDX_W-1:0] rem
);

   localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
   localparam int RECIP_W     = KEY_W + 1;
   localparam int PROD_W      = KEY_W + RECIP_W;
   localparam int RECIP_SHIFT = KEY_W + IDX_W;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << RECIP_SHIFT) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
   localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_WIDE);
   localparam logic [IDX_W-1:0]   SLOTS_LOW = IDX_W'(TABLE_SLOTS);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [IDX_W-1:0]   key_low_ff, key_low_in;
   logic [IDX_W-1:0]   rem_ff, rem_in;
   logic [IDX_W-1:0]   quot_low;

   assign quot_low = prod_ff[RECIP_SHIFT +: IDX_W];

   always_comb begin
      busy_in    = 1'b0;
      done_in    = 1'b0;
      prod_in    = prod_ff;
      key_low_in = key_low_ff;
      rem_in     = rem_ff;
      if (start) begin
         if (IS_POW2) begin
            rem_in  = key[IDX_W-1:0];
            done_in = 1'b1;
         end else begin
            prod_in    = PROD_W'(key) * PROD_W'(RECIP);
            key_low_in = key[IDX_W-1:0];
            busy_in    = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = key_low_ff - quot_low * SLOTS_LOW;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      prod_ff    <= prod_in;
      key_low_ff <= key_low_in;
      rem_ff     <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

[sv/linear_probe_hash_table.sv]
// Linear probing hash table: probe sequencer, slot memory and home slot unit.
// Each accepted word waits in the hash state for the home slot unit and then probes P slots,
// where P, the number of probed slots, is 1 to TABLE_SLOTS.
// The memory is probed one slot per cycle through its single registered read port.
// A new word is accepted the cycle after the previous result is loaded into the output
// register, so no word is taken before the previous one is done; a waiting result holds it.
// After reset a clearing pass marks every slot empty; req is not ready then.
module linear_probe_hash_table import lph_pkg::*; #(
   parameter int TABLE_SLOTS = 8
) (
   input logic        clock,
   input logic        reset,
   lph_req_if.sink    req_ch,
   lph_rsp_if.source  rsp_ch
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
   localparam logic [CNT_W-1:0] LAST_PROBE = CNT_W'(TABLE_SLOTS - 1);

   state_type                 state_ff, state_in;
   logic [OP_W-1:0]           op_ff, op_in;
   logic [KEY_W-1:0]          key_ff, key_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [IDX_W-1:0]          clr_ff, clr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic             accept;
   logic             hash_done;
   logic [IDX_W-1:0] hash_rem;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_word_type    wr_word;
   logic [IDX_W-1:0] rd_addr;
   slot_word_type    rd_word;

   logic             is_empty;
   logic             is_hit;
   logic             op_valid;
   logic             finish;
   logic             out_free;
   logic             complete;
   logic [IDX_W-1:0] next_idx;

   lph_hash #(.TABLE_SLOTS(TABLE_SLOTS), .IDX_W(IDX_W)) u_hash (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .key   (req_ch.key),
      .done  (hash_done),
      .rem   (hash_rem)
   );

   lph_slot_mem #(.TABLE_SLOTS(TABLE_SLOTS), .IDX_W(IDX_W)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_word (wr_word),
      .rd_addr (rd_addr),
      .rd_word (rd_word)
   );

   assign accept   = req_ch.valid && req_ch.ready;
   assign is_empty = rd_word.status == SLOT_EMPTY;
   assign is_hit   = (rd_word.status == SLOT_USED) && (rd_word.key == key_ff);
   assign op_valid = op_ff != OP_UNUSED;
   assign finish   = !op_valid || is_empty || is_hit || (cnt_ff == LAST_PROBE);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign complete = (state_ff == ST_PROBE) && finish && out_free;
   assign next_idx = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (finish && out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ch.ready  = state_ff == ST_IDLE;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_word       = '{status: SLOT_USED, key: key_ff, value: value_ff};
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_word = '{status: SLOT_EMPTY, key: '0, value: '0};
         end
         ST_HASH: begin
            rd_addr = hash_rem;
         end
         ST_PROBE: begin
            if (!finish) begin
               rd_addr = next_idx;
            end
            if (complete) begin
               rsp_status_in = RSP_MISS;
               rsp_value_in  = VALUE_MISS;
               unique case (op_ff)
                  OP_INSERT: begin
                     if (is_empty || is_hit) begin
                        wr_en         = 1'b1;
                        rsp_status_in = RSP_OK;
                     end else begin
                        rsp_status_in = RSP_FULL;
                     end
                  end
                  OP_LOOKUP: begin
                     if (is_hit) begin
                        rsp_status_in = RSP_OK;
                        rsp_value_in  = rd_word.value;
                     end
                  end
                  OP_DELETE: begin
                     if (is_hit) begin
                        wr_en         = 1'b1;
                        wr_word       = '{status: SLOT_TOMB, key: rd_word.key,
                                          value: rd_word.value};
                        rsp_status_in = RSP_OK;
                     end
                  end
                  default: rsp_status_in = RSP_MISS;
               endcase
            end
         end
         default: rd_addr = idx_ff;
      endcase
   end

   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff + 1'b1;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         op_in    = req_ch.opcode;
         key_in   = req_ch.key;
         value_in = req_ch.value;
      end
      if ((state_ff == ST_HASH) && hash_done) begin
         idx_in = hash_rem;
         cnt_in = '0;
      end else if ((state_ff == ST_PROBE) && !finish) begin
         idx_in = next_idx;
         cnt_in = cnt_ff + 1'b1;
      end
      if (complete) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.value_out = rsp_value_ff;

endmodule

[tb/tb_linear_probe_hash_table.sv]
// Self-checking testbench for the linear probing hash table with a shadow table predictor.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;
   import lph_pkg::*;

   localparam int TABLE_SLOTS    = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_WORDS   = 1300;
   localparam int TAIL_WORDS     = 200;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] value_out;
   } table_result_type;

   logic clock;
   logic reset;

   lph_req_if req_ch ();
   lph_rsp_if rsp_ch ();

   linear_probe_hash_table #(.TABLE_SLOTS(TABLE_SLOTS)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [1:0]                shadow_state [TABLE_SLOTS];
   logic [KEY_W-1:0]          shadow_key   [TABLE_SLOTS];
   logic signed [VALUE_W-1:0] shadow_value [TABLE_SLOTS];

   table_result_type pending_results[$];
   int               fail_count = 0;
   int               idle_cycles = 0;
   int               stall_left = 0;
   bit               gaps_enabled;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic table_result_type apply_request(logic [OP_W-1:0] op,
                                                      logic [KEY_W-1:0] key,
                                                      logic signed [VALUE_W-1:0] value);
      table_result_type res;
      int idx;
      int hit_at;
      int empty_at;
      int n;
      res.status    = RSP_MISS;
      res.value_out = VALUE_MISS;
      hit_at        = -1;
      empty_at      = -1;
      idx           = key % TABLE_SLOTS;
      for (n = 0; n < TABLE_SLOTS; n++) begin
         if (hit_at < 0 && empty_at < 0) begin
            if (shadow_state[idx] == SLOT_EMPTY) begin
               empty_at = idx;
            end else if (shadow_state[idx] == SLOT_USED && shadow_key[idx] == key) begin
               hit_at = idx;
            end
            idx = (idx + 1) % TABLE_SLOTS;
         end
      end
      case (op)
         OP_INSERT: begin
            if (hit_at >= 0) begin
               shadow_value[hit_at] = value;
               res.status = RSP_OK;
            end else if (empty_at >= 0) begin
               shadow_state[empty_at] = SLOT_USED;
               shadow_key[empty_at]   = key;
               shadow_value[empty_at] = value;
               res.status = RSP_OK;
            end else begin
               res.status = RSP_FULL;
            end
         end
         OP_LOOKUP: begin
            if (hit_at >= 0) begin
               res.status    = RSP_OK;
               res.value_out = shadow_value[hit_at];
            end
         end
         OP_DELETE: begin
            if (hit_at >= 0) begin
               shadow_state[hit_at] = SLOT_TOMB;
               res.status = RSP_OK;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic logic [KEY_W-1:0] pick_live_key();
      int live[$];
      int i;
      for (i = 0; i < TABLE_SLOTS; i++) begin
         if (shadow_state[i] == SLOT_USED) begin
            live.push_back(i);
         end
      end
      if (live.size() == 0) begin
         return KEY_W'($urandom_range(0, 31));
      end
      return shadow_key[live[$urandom_range(0, live.size() - 1)]];
   endfunction

   task automatic send_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                            logic signed [VALUE_W-1:0] value);
      int gap;
      if (gaps_enabled && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.key    <= key;
      req_ch.value  <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_results.push_back(apply_request(op, key, value));
   endtask

   task automatic release_request();
      req_ch.valid <= 1'b0;
   endtask

   task automatic send_random_word();
      logic [OP_W-1:0]           op;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] value;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         op = OP_INSERT;
      end else if (pick < 85) begin
         op = OP_LOOKUP;
      end else if (pick < 95) begin
         op = OP_DELETE;
      end else begin
         op = OP_UNUSED;
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         key = pick_live_key();
      end else if (pick < 8) begin
         key = KEY_W'($urandom_range(0, 31));
      end else begin
         key = KEY_W'($urandom);
      end
      case ($urandom_range(0, 9))
         0: value = 32'sh7FFF_FFFF;
         1: value = 32'sh8000_0000;
         2: value = -1;
         default: value = $urandom;
      endcase
      send_word(op, key, value);
   endtask

   task automatic test_basic_ops();
      send_word(OP_INSERT, 0, 32'sh7FFF_FFFF);
      send_word(OP_LOOKUP, 0, 0);
      send_word(OP_LOOKUP, 4, 0);
      send_word(OP_UNUSED, 0, -1);
      send_word(OP_DELETE, 4, 0);
   endtask

   task automatic test_probe_wrap_and_tombstones();
      send_word(OP_INSERT, 7, 32'sh8000_0000);
      send_word(OP_INSERT, 15, 32'sh1234_5678);
      send_word(OP_LOOKUP, 15, 0);
      send_word(OP_INSERT, 15, 0);
      send_word(OP_LOOKUP, 15, -1);
      send_word(OP_DELETE, 7, 0);
      send_word(OP_LOOKUP, 15, 0);
      send_word(OP_LOOKUP, 7, 0);
      send_word(OP_DELETE, 7, 0);
      send_word(OP_INSERT, 7, -1);
      send_word(OP_LOOKUP, 7, 0);
   endtask

   task automatic test_full_table();
      send_word(OP_INSERT, 31'h7FFF_FFFF, 32'sh5555_5555);
      send_word(OP_LOOKUP, 31'h7FFF_FFFF, 0);
      send_word(OP_INSERT, 4, 32'sh2AAA_AAAA);
      send_word(OP_INSERT, 5, 32'sh0000_0001);
      send_word(OP_INSERT, 6, 32'shFFFF_FFFE);
      send_word(OP_INSERT, 8, 32'sh0BAD_0BAD);
      send_word(OP_LOOKUP, 16, 0);
      send_word(OP_DELETE, 9, 0);
      send_word(OP_INSERT, 5, 32'sh7654_3210);
      send_word(OP_LOOKUP, 5, 0);
   endtask

   task automatic test_random_traffic();
      int i;
      for (i = 0; i < RANDOM_WORDS; i++) begin
         gaps_enabled = ((i / 150) % 3) != 2;
         send_random_word();
      end
   endtask

   task automatic test_drain_pause();
      int i;
      gaps_enabled = 1'b1;
      for (i = 0; i < 5; i++) begin
         send_random_word();
      end
      release_request();
      while (pending_results.size() != 0) @(posedge clock);
      for (i = 0; i < 5; i++) begin
         send_random_word();
      end
   endtask

   task automatic test_back_to_back();
      int i;
      gaps_enabled = 1'b0;
      for (i = 0; i < TAIL_WORDS; i++) begin
         send_random_word();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 17);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result word: status %0d, value_out %0d",
                   rsp_ch.status, rsp_ch.value_out);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
               fail_count++;
            end
            if (rsp_ch.value_out !== want.value_out) begin
               $error("value_out: expected %0d, actual %0d", want.value_out,
                      rsp_ch.value_out);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int i;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.opcode  = OP_INSERT;
      req_ch.key     = '0;
      req_ch.value   = '0;
      gaps_enabled   = 1'b1;
      for (i = 0; i < TABLE_SLOTS; i++) begin
         shadow_state[i] = SLOT_EMPTY;
         shadow_key[i]   = '0;
         shadow_value[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_probe_wrap_and_tombstones();
      test_full_table();
      test_random_traffic();
      test_drain_pause();
      test_back_to_back();
      release_request();

      while (pending_results.size() != 0) @(posedge clock);
      repeat (TABLE_SLOTS + 40) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
